### hw/rtl/lse_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_pkg
// Shared types and constants for the LSB stego extractor: decoder phase
// codes, field widths and the marker register reset value.
// ----------------------------------------------------------------------------
package lse_pkg;

    localparam int MARKER_BITS_DEF = 24;
    localparam int LENGTH_BITS_DEF = 32;

    localparam int CHAN_W     = 8;
    localparam int BYTE_W     = 8;
    localparam int BYTE_CNT_W = 3;
    localparam int STATUS_W   = 2;
    localparam int MSG_LEN_W  = 32;
    localparam int MARKER_W   = 24;
    localparam int PIX_BITS   = 3;

    localparam logic [MARKER_W-1:0] MARKER_RESET = 24'hE29DA4;

    typedef enum logic [STATUS_W-1:0] {
        PH_HEADER   = 2'd0,
        PH_MESSAGE  = 2'd1,
        PH_DONE     = 2'd2,
        PH_NOTFOUND = 2'd3
    } phase_t;

endpackage
`default_nettype wire

### hw/rtl/lsb_stego_extractor.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lsb_stego_extractor
// Recovers a hidden message from bit 0 of the red, green and blue channels
// of a raster pixel stream: marker check, byte count, then message bytes.
// ----------------------------------------------------------------------------
// One pixel word is taken per clock cycle unless the sink stalls, with a
// result word out in the next cycle. The three hidden bits of a pixel are
// folded into the decoder state by a single combinational pass and the state
// registers and the result register are loaded at the same edge, so the rate
// is set by that pass alone. The result register holds a word while the sink
// stalls and the input stays ready whenever that word is taken in the same
// cycle. The marker register may be written at any time the block is idle.
// ----------------------------------------------------------------------------
module lsb_stego_extractor #(
    parameter int MARKER_BITS = lse_pkg::MARKER_BITS_DEF,
    parameter int LENGTH_BITS = lse_pkg::LENGTH_BITS_DEF
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            s_valid,
    output logic                                 s_ready,
    input  wire logic [lse_pkg::CHAN_W-1:0]      s_red,
    input  wire logic [lse_pkg::CHAN_W-1:0]      s_green,
    input  wire logic [lse_pkg::CHAN_W-1:0]      s_blue,
    input  wire logic                            s_first_pixel,
    output logic                                 m_valid,
    input  wire logic                            m_ready,
    output logic [lse_pkg::BYTE_W-1:0]           m_msg_byte,
    output logic                                 m_byte_valid,
    output logic                                 m_last_byte,
    output logic [lse_pkg::STATUS_W-1:0]         m_status,
    output logic [lse_pkg::MSG_LEN_W-1:0]        m_msg_length,
    input  wire logic                            cfg_valid,
    output logic                                 cfg_ready,
    input  wire logic [lse_pkg::MARKER_W-1:0]    cfg_data
);
    import lse_pkg::*;

    localparam int HDR_MAX = (MARKER_BITS > LENGTH_BITS) ? MARKER_BITS : LENGTH_BITS;
    localparam int HCW     = $clog2(HDR_MAX);
    localparam int MIW     = $clog2(MARKER_BITS);

    logic [MARKER_W-1:0]    marker_reg;
    phase_t                 phase_reg, phase_next;
    logic [HCW-1:0]         hcnt_reg, hcnt_next;
    logic                   in_len_reg, in_len_next;
    logic [LENGTH_BITS-1:0] len_reg, len_next;
    logic [LENGTH_BITS-1:0] left_reg, left_next;
    logic [BYTE_W-1:0]      bsh_reg, bsh_next;
    logic [BYTE_CNT_W-1:0]  bcnt_reg, bcnt_next;

    logic                   m_valid_reg;
    logic [BYTE_W-1:0]      msg_byte_reg, msg_byte_next;
    logic                   byte_valid_reg, byte_valid_next;
    logic                   last_byte_reg, last_byte_next;
    logic [STATUS_W-1:0]    status_reg;
    logic [MSG_LEN_W-1:0]   msg_length_reg, msg_length_next;

    logic [MARKER_BITS-1:0] marker_ext;
    logic                   pix_bit [0:PIX_BITS-1];
    logic                   take;

    // marker positions beyond the register read as zero
    for (genvar k = 0; k < MARKER_BITS; k++) begin : g_mk
        if (k < MARKER_W) begin : g_reg
            assign marker_ext[k] = marker_reg[k];
        end else begin : g_zero
            assign marker_ext[k] = 1'b0;
        end
    end

    assign pix_bit[0] = s_red[0];
    assign pix_bit[1] = s_green[0];
    assign pix_bit[2] = s_blue[0];

    assign s_ready   = !m_valid_reg || m_ready;
    assign take      = s_valid && s_ready;
    assign cfg_ready = 1'b1;

    always_comb begin
        phase_next      = phase_reg;
        hcnt_next       = hcnt_reg;
        in_len_next     = in_len_reg;
        len_next        = len_reg;
        left_next       = left_reg;
        bsh_next        = bsh_reg;
        bcnt_next       = bcnt_reg;
        msg_byte_next   = '0;
        byte_valid_next = 1'b0;
        last_byte_next  = 1'b0;

        if (s_first_pixel) begin
            phase_next  = PH_HEADER;
            hcnt_next   = '0;
            in_len_next = 1'b0;
            len_next    = '0;
            left_next   = '0;
            bsh_next    = '0;
            bcnt_next   = '0;
        end

        for (int i = 0; i < PIX_BITS; i++) begin
            if (phase_next == PH_HEADER && !in_len_next) begin
                if (pix_bit[i] != marker_ext[MIW'(MARKER_BITS - 1) - MIW'(hcnt_next)]) begin
                    phase_next = PH_NOTFOUND;
                end else if ((HCW+1)'(hcnt_next) + 1'b1 == (HCW+1)'(MARKER_BITS)) begin
                    hcnt_next   = '0;
                    in_len_next = 1'b1;
                    len_next    = '0;
                end else begin
                    hcnt_next = hcnt_next + 1'b1;
                end
            end else if (phase_next == PH_HEADER) begin
                len_next = {len_next[LENGTH_BITS-2:0], pix_bit[i]};
                if ((HCW+1)'(hcnt_next) + 1'b1 == (HCW+1)'(LENGTH_BITS)) begin
                    hcnt_next   = '0;
                    in_len_next = 1'b0;
                    left_next   = len_next;
                    bsh_next    = '0;
                    bcnt_next   = '0;
                    phase_next  = (len_next == '0) ? PH_DONE : PH_MESSAGE;
                end else begin
                    hcnt_next = hcnt_next + 1'b1;
                end
            end else if (phase_next == PH_MESSAGE) begin
                bsh_next  = {bsh_next[BYTE_W-2:0], pix_bit[i]};
                bcnt_next = bcnt_next + 1'b1;
                if (bcnt_next == '0) begin
                    msg_byte_next   = bsh_next;
                    byte_valid_next = 1'b1;
                    bsh_next        = '0;
                    left_next       = left_next - 1'b1;
                    if (left_next == '0) begin
                        last_byte_next = 1'b1;
                        phase_next     = PH_DONE;
                    end
                end
            end
        end

        if ((phase_next == PH_MESSAGE || phase_next == PH_DONE) && !in_len_next) begin
            msg_length_next = MSG_LEN_W'(len_next);
        end else begin
            msg_length_next = '0;
        end
    end

    // decoder state and control
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            marker_reg  <= MARKER_RESET;
            phase_reg   <= PH_HEADER;
            hcnt_reg    <= '0;
            in_len_reg  <= 1'b0;
            len_reg     <= '0;
            left_reg    <= '0;
            bsh_reg     <= '0;
            bcnt_reg    <= '0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                marker_reg <= cfg_data;
            end
            if (take) begin
                phase_reg  <= phase_next;
                hcnt_reg   <= hcnt_next;
                in_len_reg <= in_len_next;
                len_reg    <= len_next;
                left_reg   <= left_next;
                bsh_reg    <= bsh_next;
                bcnt_reg   <= bcnt_next;
            end
            if (take) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
        end
    end

    // result word
    always_ff @(posedge aclk) begin
        if (take) begin
            msg_byte_reg   <= msg_byte_next;
            byte_valid_reg <= byte_valid_next;
            last_byte_reg  <= last_byte_next;
            status_reg     <= phase_next;
            msg_length_reg <= msg_length_next;
        end
    end

    assign m_valid      = m_valid_reg;
    assign m_msg_byte   = msg_byte_reg;
    assign m_byte_valid = byte_valid_reg;
    assign m_last_byte  = last_byte_reg;
    assign m_status     = status_reg;
    assign m_msg_length = msg_length_reg;

endmodule
`default_nettype wire

### hw/rtl/lse_checker.sv
`default_nettype none
// ----------------------------------------------------------------------------
// lse_checker
// Port-level checks for the LSB stego extractor result channel, bound to
// the top level.
// ----------------------------------------------------------------------------
module lse_checker (
    input wire logic                            aclk,
    input wire logic                            aresetn,
    input wire logic                            m_valid,
    input wire logic                            m_ready,
    input wire logic [lse_pkg::BYTE_W-1:0]      m_msg_byte,
    input wire logic                            m_byte_valid,
    input wire logic                            m_last_byte,
    input wire logic [lse_pkg::STATUS_W-1:0]    m_status,
    input wire logic [lse_pkg::MSG_LEN_W-1:0]   m_msg_length
);
    import lse_pkg::*;

    // stalled result word holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_msg_byte) && $stable(m_status)
            && $stable(m_msg_length) && $stable(m_byte_valid))
        else $error("result word changed while stalled");

    // last byte only with a byte and only when the message ends
    a_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_last_byte |-> m_byte_valid && m_status == PH_DONE)
        else $error("last byte flag outside message end");

    // bytes only come out of the message phase
    a_byte: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_byte_valid |-> m_status == PH_MESSAGE || m_status == PH_DONE)
        else $error("byte emitted outside message phase");

    // no length shown before the header is complete
    a_len: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && (m_status == PH_HEADER || m_status == PH_NOTFOUND)
            |-> m_msg_length == '0)
        else $error("length shown before header complete");

endmodule

bind lsb_stego_extractor lse_checker u_lse_checker (
    .aclk         (aclk),
    .aresetn      (aresetn),
    .m_valid      (m_valid),
    .m_ready      (m_ready),
    .m_msg_byte   (m_msg_byte),
    .m_byte_valid (m_byte_valid),
    .m_last_byte  (m_last_byte),
    .m_status     (m_status),
    .m_msg_length (m_msg_length)
);
`default_nettype wire

### tb/lsb_stego_extractor_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// lsb_stego_extractor_test
// Self-checking bench for the LSB stego extractor. Pixels are built from a
// bit stream of marker, byte count and message bytes, with broken markers,
// huge counts and noise mixed in. A behavioural decoder in the bench predicts
// every result word, and the words are compared field by field while both
// handshakes idle and stall at random over several marker settings.
// ----------------------------------------------------------------------------
module lsb_stego_extractor_test;
    import lse_pkg::*;

    localparam real HALF_PERIOD = 6.0;
    localparam int  WATCHDOG_NS = 6_000_000;

    typedef struct {
        logic [BYTE_W-1:0]    msg_byte;
        logic                 byte_valid;
        logic                 last_byte;
        phase_t               status;
        logic [MSG_LEN_W-1:0] msg_length;
    } pixel_result_t;

    typedef struct {
        logic [CHAN_W-1:0] red;
        logic [CHAN_W-1:0] green;
        logic [CHAN_W-1:0] blue;
        logic              first;
        phase_t            status;
    } pixel_row_t;

    logic                 aclk = 1'b0;
    logic                 aresetn;
    logic                 s_valid;
    logic                 s_ready;
    logic [CHAN_W-1:0]    s_red;
    logic [CHAN_W-1:0]    s_green;
    logic [CHAN_W-1:0]    s_blue;
    logic                 s_first_pixel;
    logic                 m_valid;
    logic                 m_ready;
    logic [BYTE_W-1:0]    m_msg_byte;
    logic                 m_byte_valid;
    logic                 m_last_byte;
    logic [STATUS_W-1:0]  m_status;
    logic [MSG_LEN_W-1:0] m_msg_length;
    logic                 cfg_valid;
    logic                 cfg_ready;
    logic [MARKER_W-1:0]  cfg_data;

    // decoder copy
    logic [MARKER_W-1:0]  marker_word;
    phase_t               dec_phase;
    int                   dec_hdr_count;
    logic                 dec_in_length;
    logic [MSG_LEN_W-1:0] dec_length_shift;
    logic [MSG_LEN_W-1:0] dec_bytes_left;
    logic [BYTE_W-1:0]    dec_byte_shift;
    logic [BYTE_CNT_W-1:0] dec_bit_count;

    pixel_result_t expected_results[$];
    int mismatches = 0;
    int pixels_sent = 0;
    int idle_pct = 0;
    int stall_pct = 0;

    pixel_row_t directed_pixels [8] = '{
        '{8'hFF, 8'hFF, 8'hFF, 1'b0, PH_HEADER},
        '{8'h00, 8'h00, 8'h00, 1'b0, PH_HEADER},
        '{8'hFE, 8'hFE, 8'hFE, 1'b0, PH_NOTFOUND},
        '{8'h01, 8'h01, 8'h01, 1'b0, PH_NOTFOUND},
        '{8'h80, 8'h80, 8'h80, 1'b1, PH_NOTFOUND},
        '{8'h7F, 8'hFF, 8'h01, 1'b1, PH_HEADER},
        '{8'h01, 8'hFF, 8'hFE, 1'b0, PH_NOTFOUND},
        '{8'hFF, 8'h00, 8'hFF, 1'b1, PH_NOTFOUND}
    };

    lsb_stego_extractor u_top (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .s_valid       (s_valid),
        .s_ready       (s_ready),
        .s_red         (s_red),
        .s_green       (s_green),
        .s_blue        (s_blue),
        .s_first_pixel (s_first_pixel),
        .m_valid       (m_valid),
        .m_ready       (m_ready),
        .m_msg_byte    (m_msg_byte),
        .m_byte_valid  (m_byte_valid),
        .m_last_byte   (m_last_byte),
        .m_status      (m_status),
        .m_msg_length  (m_msg_length),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_data      (cfg_data)
    );

    always #(HALF_PERIOD) aclk = ~aclk;

    function automatic void clear_decoder();
        dec_phase        = PH_HEADER;
        dec_hdr_count    = 0;
        dec_in_length    = 1'b0;
        dec_length_shift = '0;
        dec_bytes_left   = '0;
        dec_byte_shift   = '0;
        dec_bit_count    = '0;
    endfunction

    function automatic pixel_result_t decode_pixel(input logic [2:0] bits, input logic first);
        pixel_result_t res;
        logic          b;
        int            i;
        res.msg_byte   = '0;
        res.byte_valid = 1'b0;
        res.last_byte  = 1'b0;
        if (first) begin
            clear_decoder();
        end
        for (i = 0; i < PIX_BITS; i++) begin
            b = bits[i];
            if (dec_phase == PH_HEADER && !dec_in_length) begin
                if (b != marker_word[MARKER_BITS_DEF-1-dec_hdr_count]) begin
                    dec_phase = PH_NOTFOUND;
                end else begin
                    dec_hdr_count++;
                    if (dec_hdr_count >= MARKER_BITS_DEF) begin
                        dec_hdr_count    = 0;
                        dec_in_length    = 1'b1;
                        dec_length_shift = '0;
                    end
                end
            end else if (dec_phase == PH_HEADER) begin
                dec_length_shift = {dec_length_shift[MSG_LEN_W-2:0], b};
                dec_hdr_count++;
                if (dec_hdr_count >= LENGTH_BITS_DEF) begin
                    dec_hdr_count  = 0;
                    dec_in_length  = 1'b0;
                    dec_bytes_left = dec_length_shift;
                    dec_byte_shift = '0;
                    dec_bit_count  = '0;
                    dec_phase      = (dec_bytes_left == 0) ? PH_DONE : PH_MESSAGE;
                end
            end else if (dec_phase == PH_MESSAGE) begin
                dec_byte_shift = {dec_byte_shift[BYTE_W-2:0], b};
                dec_bit_count  = dec_bit_count + 1'b1;
                if (dec_bit_count == 0) begin
                    res.msg_byte   = dec_byte_shift;
                    res.byte_valid = 1'b1;
                    dec_byte_shift = '0;
                    dec_bytes_left = dec_bytes_left - 1'b1;
                    if (dec_bytes_left == 0) begin
                        res.last_byte = 1'b1;
                        dec_phase     = PH_DONE;
                    end
                end
            end
        end
        res.status     = dec_phase;
        res.msg_length = ((dec_phase == PH_MESSAGE || dec_phase == PH_DONE) && !dec_in_length)
                         ? dec_length_shift : '0;
        return res;
    endfunction

    function automatic logic [CHAN_W-1:0] channel_with(input logic b);
        logic [CHAN_W-1:0] v;
        v    = CHAN_W'($urandom);
        v[0] = b;
        return v;
    endfunction

    task automatic flag_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
        $display("[%0t] mismatch on %s: got 0x%0h, want 0x%0h", $realtime, what, got, want);
        mismatches++;
    endtask

    // sink side: random stalls and result checking
    always @(posedge aclk) begin
        pixel_result_t want;
        m_ready <= ($urandom_range(99) >= stall_pct);
        if (aresetn && m_valid && m_ready) begin
            if (expected_results.size() == 0) begin
                flag_mismatch("word with nothing pending", {61'd0, m_status, m_byte_valid}, 0);
            end else begin
                want = expected_results.pop_front();
                if (m_msg_byte !== want.msg_byte)
                    flag_mismatch("msg_byte", m_msg_byte, want.msg_byte);
                if (m_byte_valid !== want.byte_valid)
                    flag_mismatch("byte_valid", m_byte_valid, want.byte_valid);
                if (m_last_byte !== want.last_byte)
                    flag_mismatch("last_byte", m_last_byte, want.last_byte);
                if (m_status !== want.status)
                    flag_mismatch("status", m_status, want.status);
                if (m_msg_length !== want.msg_length)
                    flag_mismatch("msg_length", m_msg_length, want.msg_length);
            end
        end
    end

    task automatic send_pixel(input logic [CHAN_W-1:0] r, input logic [CHAN_W-1:0] g,
                              input logic [CHAN_W-1:0] b, input logic first,
                              input bit typed, input phase_t typed_status);
        pixel_result_t want;
        while ($urandom_range(99) < idle_pct) begin
            s_valid <= 1'b0;
            @(posedge aclk);
        end
        s_valid       <= 1'b1;
        s_red         <= r;
        s_green       <= g;
        s_blue        <= b;
        s_first_pixel <= first;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        want = decode_pixel({b[0], g[0], r[0]}, first);
        if (typed) begin
            want.msg_byte   = '0;
            want.byte_valid = 1'b0;
            want.last_byte  = 1'b0;
            want.status     = typed_status;
            want.msg_length = '0;
        end
        expected_results.push_back(want);
        pixels_sent++;
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        while (expected_results.size() != 0) @(posedge aclk);
        repeat (4) @(posedge aclk);
    endtask

    task automatic write_marker(input logic [MARKER_W-1:0] value);
        wait_drained();
        cfg_valid <= 1'b1;
        cfg_data  <= value;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        cfg_valid   <= 1'b0;
        marker_word = value;
    endtask

    // flip < 0 keeps the marker intact; fill < 0 gives random message bytes
    task automatic send_image(input int flip, input logic [MSG_LEN_W-1:0] len,
                              input int nbytes, input int fill, input int trail);
        bit                stream[$];
        logic [BYTE_W-1:0] byte_v;
        logic [2:0]        bits;
        logic              first;
        int                k;
        int                n;
        for (k = 0; k < MARKER_BITS_DEF; k++)
            stream.push_back(marker_word[MARKER_BITS_DEF-1-k] ^ (k == flip));
        for (k = LENGTH_BITS_DEF - 1; k >= 0; k--)
            stream.push_back(len[k]);
        for (n = 0; n < nbytes; n++) begin
            byte_v = (fill < 0) ? BYTE_W'($urandom) : BYTE_W'(fill);
            for (k = BYTE_W - 1; k >= 0; k--)
                stream.push_back(byte_v[k]);
        end
        first = 1'b1;
        while (stream.size() != 0) begin
            for (k = 0; k < PIX_BITS; k++)
                bits[k] = (stream.size() != 0) ? stream.pop_front() : 1'($urandom);
            send_pixel(channel_with(bits[0]), channel_with(bits[1]), channel_with(bits[2]),
                       first, 1'b0, PH_HEADER);
            first = 1'b0;
        end
        repeat (trail)
            send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom), 1'b0,
                       1'b0, PH_HEADER);
    endtask

    task automatic random_image();
        int pick;
        int n;
        pick = $urandom_range(99);
        if ($urandom_range(39) == 0) begin
            wait_drained();
        end
        if (pick < 10) begin
            n = $urandom_range(1, 5);
            repeat (n)
                send_pixel(CHAN_W'($urandom), CHAN_W'($urandom), CHAN_W'($urandom),
                           ($urandom_range(7) == 0), 1'b0, PH_HEADER);
        end else if (pick < 22) begin
            send_image($urandom_range(MARKER_BITS_DEF - 1), $urandom_range(3), 1, -1,
                       $urandom_range(2));
        end else if (pick < 30) begin
            send_image(-1, $urandom, $urandom_range(4), -1, 0);
        end else begin
            n = $urandom_range(5);
            send_image(-1, n, n, -1, $urandom_range(3));
        end
    endtask

    task automatic run_phase(input int idle, input int stall, input logic [MARKER_W-1:0] m,
                             input int count);
        int target;
        write_marker(m);
        idle_pct  = idle;
        stall_pct = stall;
        target    = pixels_sent + count;
        while (pixels_sent < target) random_image();
    endtask

    initial begin
        int i;
        aresetn       <= 1'b0;
        s_valid       <= 1'b0;
        s_red         <= '0;
        s_green       <= '0;
        s_blue        <= '0;
        s_first_pixel <= 1'b0;
        m_ready       <= 1'b0;
        cfg_valid     <= 1'b0;
        cfg_data      <= '0;
        marker_word   = MARKER_RESET;
        clear_decoder();
        repeat (4) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // search is armed straight out of reset, so the first rows carry no first_pixel
        for (i = 0; i < $size(directed_pixels); i++)
            send_pixel(directed_pixels[i].red, directed_pixels[i].green,
                       directed_pixels[i].blue, directed_pixels[i].first,
                       1'b1, directed_pixels[i].status);
        send_image(-1, 0, 0, -1, 2);
        send_image(-1, 1, 1, 8'hFF, 1);
        send_image(-1, 2, 2, 8'h00, 0);

        run_phase(0, 0, 24'h000000, 350);
        run_phase(62, 0, 24'hFFFFFF, 350);
        run_phase(0, 62, MARKER_W'($urandom), 350);
        run_phase(32, 32, MARKER_W'($urandom), 350);
        run_phase(0, 0, MARKER_RESET, 350);

        wait_drained();
        repeat (8) @(posedge aclk);
        if (mismatches == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

    initial begin
        #(WATCHDOG_NS);
        $display("status: fail");
        $finish;
    end

endmodule

### files.f
hw/rtl/lse_pkg.sv
hw/rtl/lsb_stego_extractor.sv
hw/rtl/lse_checker.sv
tb/lsb_stego_extractor_test.sv
